// File: hdl/adjm_pkg.sv
`default_nettype none

package adjm_pkg;

   localparam int DEF_MAX_VERTICES = 16;

   localparam int REQ_W    = 2;
   localparam int VERTEX_W = 4;
   localparam int VCOUNT_W = 5;
   localparam int COUNT_W  = 5;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LIST  = 2'd2;

   localparam logic REG_VCOUNT = 1'b0;
   localparam logic REG_UNDIR  = 1'b1;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
   localparam logic                UNDIR_RESET  = 1'b0;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

// File: hdl/adjacency_matrix_store.sv
// Adjacency-matrix edge store.
// Request channel: start with req_type (add, query, list), req_from_vertex and
// req_to_vertex. A transaction is taken at a clock edge with start high and
// busy low; busy stays high until the request has finished.
// Result channel: each result shows for one cycle with rsp_valid high; the
// receiver must take it then. rsp_last marks the final result of a request.
// Add and query give one result in the cycle after acceptance; an undirected
// add of two distinct vertices gives its result from a second state, because
// the second row needs its own read-modify-write on the row memory.
// A list of an empty row gives one result after the row read; otherwise the
// row read is followed by one neighbor out per cycle, from a priority scan
// of the fetched row.
// Out-of-range indices give one error result and change nothing; request
// code 3 gives no result and frees the block after the read state.
// Configuration: APB-style, vertex_count at 0x0 and undirected at 0x4.
// Reset clears the matrix at once through per-row valid bits and sets
// vertex_count to 16 and undirected to 0.
`default_nettype none

module adjacency_matrix_store #(
   parameter int MAX_VERTICES = adjm_pkg::DEF_MAX_VERTICES
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [adjm_pkg::REQ_W-1:0]         req_type,
   input  wire  [adjm_pkg::VERTEX_W-1:0]      req_from_vertex,
   input  wire  [adjm_pkg::VERTEX_W-1:0]      req_to_vertex,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic                               rsp_is_adjacent,
   output logic                               rsp_found,
   output logic [adjm_pkg::VERTEX_W-1:0]      rsp_neighbor,
   output logic [adjm_pkg::COUNT_W-1:0]       rsp_neighbor_count,
   output logic                               rsp_last,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [adjm_pkg::CSR_AW-1:0]        paddr,
   input  wire  [adjm_pkg::CSR_DW-1:0]        pwdata,
   output logic [adjm_pkg::CSR_DW-1:0]        prdata,
   output logic                               pready
);
   import adjm_pkg::*;

   localparam int ROWS = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int AW   = $clog2(ROWS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_ADD2 = 2'd2;
   localparam logic [1:0] S_LIST = 2'd3;

   localparam logic [ROWS-1:0] ONE_ROW = {{(ROWS-1){1'b0}}, 1'b1};

   logic [1:0]            state_ff, state_in;
   logic [REQ_W-1:0]      req_ff, req_in;
   logic [VERTEX_W-1:0]   from_ff, from_in;
   logic [VERTEX_W-1:0]   to_ff, to_in;
   logic                  err_ff, err_in;
   logic [ROWS-1:0]       scan_ff, scan_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [VCOUNT_W-1:0]   vcount_ff;
   logic                  undir_ff;

   logic [ROWS-1:0]       mem [ROWS];
   logic [ROWS-1:0]       valid_ff;
   logic [ROWS-1:0]       rd_row_ff;
   logic                  rd_valid_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ROWS-1:0]       wr_data;

   logic [VCOUNT_W-1:0]   lim;
   logic [ROWS-1:0]       lim_mask;
   logic [ROWS-1:0]       row_q;
   logic [ROWS-1:0]       listed;
   logic [AW-1:0]         low;
   logic [ROWS-1:0]       rest;
   logic                  csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_UNDIR) ? {{(CSR_DW-1){1'b0}}, undir_ff}
                                           : {{(CSR_DW-VCOUNT_W){1'b0}}, vcount_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
         undir_ff  <= UNDIR_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_UNDIR) begin
            undir_ff <= pwdata[0];
         end else begin
            vcount_ff <= pwdata[VCOUNT_W-1:0];
         end
      end
   end

   always_comb begin
      if (vcount_ff > VCOUNT_W'(ROWS)) begin
         lim = VCOUNT_W'(ROWS);
      end else begin
         lim = vcount_ff;
      end
      for (int i = 0; i < ROWS; i++) begin
         lim_mask[i] = (VCOUNT_W'(i) < lim);
      end
   end

   assign row_q  = rd_valid_ff ? rd_row_ff : '0;
   assign listed = row_q & lim_mask;
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      low = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (scan_ff[i]) begin
            low = AW'(i);
         end
      end
      rest = scan_ff & ~(ONE_ROW << low);
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      from_in  = from_ff;
      to_in    = to_ff;
      err_in   = err_ff;
      scan_in  = scan_ff;
      cnt_in   = cnt_ff;
      rd_addr  = req_from_vertex[AW-1:0];
      wr_en    = 1'b0;
      wr_addr  = from_ff[AW-1:0];
      wr_data  = row_q | (ONE_ROW << to_ff[AW-1:0]);

      rsp_valid          = 1'b0;
      rsp_status         = STATUS_OK;
      rsp_is_adjacent    = 1'b0;
      rsp_found          = 1'b0;
      rsp_neighbor       = '0;
      rsp_neighbor_count = '0;
      rsp_last           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_type;
               from_in  = req_from_vertex;
               to_in    = req_to_vertex;
               err_in   = ({1'b0, req_from_vertex} >= lim) ||
                          ((req_type != REQ_LIST) && ({1'b0, req_to_vertex} >= lim));
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
            if (req_ff inside {REQ_ADD, REQ_QUERY, REQ_LIST}) begin
               if (err_ff) begin
                  rsp_valid  = 1'b1;
                  rsp_status = STATUS_ERR;
                  rsp_last   = 1'b1;
               end else begin
                  case (req_ff)
                     REQ_ADD: begin
                        wr_en = 1'b1;
                        if (undir_ff && (to_ff != from_ff)) begin
                           rd_addr  = to_ff[AW-1:0];
                           state_in = S_ADD2;
                        end else begin
                           rsp_valid = 1'b1;
                           rsp_last  = 1'b1;
                        end
                     end
                     REQ_QUERY: begin
                        rsp_valid       = 1'b1;
                        rsp_is_adjacent = row_q[to_ff[AW-1:0]];
                        rsp_last        = 1'b1;
                     end
                     default: begin
                        if (listed == '0) begin
                           rsp_valid = 1'b1;
                           rsp_last  = 1'b1;
                        end else begin
                           scan_in  = listed;
                           cnt_in   = '0;
                           state_in = S_LIST;
                        end
                     end
                  endcase
               end
            end
         end
         S_ADD2: begin
            wr_en     = 1'b1;
            wr_addr   = to_ff[AW-1:0];
            wr_data   = row_q | (ONE_ROW << from_ff[AW-1:0]);
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            state_in  = S_IDLE;
         end
         S_LIST: begin
            rsp_valid    = 1'b1;
            rsp_found    = 1'b1;
            rsp_neighbor = VERTEX_W'(low);
            scan_in      = rest;
            cnt_in       = cnt_ff + 1'b1;
            if (rest == '0) begin
               rsp_last           = 1'b1;
               rsp_neighbor_count = cnt_ff + 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      from_ff <= from_in;
      to_ff   <= to_in;
      err_ff  <= err_in;
      scan_ff <= scan_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset) !busy |-> !rsp_valid)
      else $error("result outside an active transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ERR) |-> rsp_last && !rsp_found)
      else $error("error result must be a single final result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_found)
      else $error("neighbor list interrupted");

   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule

`default_nettype wire

// File: test/tb_adjacency_matrix_store.sv
`timescale 1ns / 100ps

module tb_adjacency_matrix_store;
   import adjm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int NUM_V         = DEF_MAX_VERTICES;
   localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

   typedef struct packed {
      logic                status;
      logic                is_adjacent;
      logic                found;
      logic [VERTEX_W-1:0] neighbor;
      logic [COUNT_W-1:0]  neighbor_count;
      logic                last;
   } answer_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [VERTEX_W-1:0] req_from_vertex;
   logic [VERTEX_W-1:0] req_to_vertex;
   logic                rsp_valid;
   logic                rsp_status;
   logic                rsp_is_adjacent;
   logic                rsp_found;
   logic [VERTEX_W-1:0] rsp_neighbor;
   logic [COUNT_W-1:0]  rsp_neighbor_count;
   logic                rsp_last;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // shadow copy of the edge matrix and registers
   logic [NUM_V-1:0]    graph_rows [NUM_V];
   logic [VCOUNT_W-1:0] vcount_shadow;
   logic                undir_shadow;
   answer_type          answer_q [$];
   int                  mismatches;
   bit                  no_gaps;

   adjacency_matrix_store u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_from_vertex    (req_from_vertex),
      .req_to_vertex      (req_to_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_is_adjacent    (rsp_is_adjacent),
      .rsp_found          (rsp_found),
      .rsp_neighbor       (rsp_neighbor),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_adjacency_matrix_store: done, errors");
      $finish;
   end

   function automatic int vertex_limit();
      return (vcount_shadow > NUM_V) ? NUM_V : int'(vcount_shadow);
   endfunction

   function automatic answer_type make_answer(logic st, logic adj, logic fnd,
                                              logic [VERTEX_W-1:0] nb,
                                              logic [COUNT_W-1:0] cnt, logic lst);
      answer_type a;
      a.status         = st;
      a.is_adjacent    = adj;
      a.found          = fnd;
      a.neighbor       = nb;
      a.neighbor_count = cnt;
      a.last           = lst;
      return a;
   endfunction

   function automatic string fmt_answer(answer_type a);
      return $sformatf("st=%0d adj=%0d fnd=%0d nb=%0d cnt=%0d last=%0d",
                       a.status, a.is_adjacent, a.found, a.neighbor,
                       a.neighbor_count, a.last);
   endfunction

   function automatic void apply_graph_request(logic [REQ_W-1:0] kind,
                                               logic [VERTEX_W-1:0] src,
                                               logic [VERTEX_W-1:0] dst);
      int lim;
      int total;
      int k;
      lim = vertex_limit();
      case (kind)
         REQ_ADD, REQ_QUERY: begin
            if (src >= lim || dst >= lim) begin
               answer_q.push_back(make_answer(STATUS_ERR, 1'b0, 1'b0, '0, '0, 1'b1));
            end else if (kind == REQ_ADD) begin
               graph_rows[src][dst] = 1'b1;
               if (undir_shadow)
                  graph_rows[dst][src] = 1'b1;
               answer_q.push_back(make_answer(STATUS_OK, 1'b0, 1'b0, '0, '0, 1'b1));
            end else begin
               answer_q.push_back(make_answer(STATUS_OK, graph_rows[src][dst],
                                              1'b0, '0, '0, 1'b1));
            end
         end
         REQ_LIST: begin
            if (src >= lim) begin
               answer_q.push_back(make_answer(STATUS_ERR, 1'b0, 1'b0, '0, '0, 1'b1));
            end else begin
               total = 0;
               for (int t = 0; t < lim; t++)
                  if (graph_rows[src][t])
                     total++;
               if (total == 0) begin
                  answer_q.push_back(make_answer(STATUS_OK, 1'b0, 1'b0, '0, '0, 1'b1));
               end else begin
                  k = 0;
                  for (int t = 0; t < lim; t++) begin
                     if (graph_rows[src][t]) begin
                        k++;
                        answer_q.push_back(make_answer(STATUS_OK, 1'b0, 1'b1,
                           VERTEX_W'(t), (k == total) ? COUNT_W'(total) : '0,
                           k == total));
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic note_mismatch(string what, answer_type want, answer_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s): exp %s | got %s", $realtime, what,
                  fmt_answer(want), fmt_answer(got));
   endtask

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_is_adjacent, rsp_found, rsp_neighbor,
                rsp_neighbor_count, rsp_last};
         if (answer_q.size() == 0) begin
            note_mismatch("unexpected", '0, got);
         end else begin
            want = answer_q.pop_front();
            if (got !== want)
               note_mismatch("field", want, got);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 24);
   endfunction

   function automatic logic [VERTEX_W-1:0] pick_vertex(int hot);
      int lim;
      int r;
      lim = vertex_limit();
      r = $urandom_range(0, 99);
      if (lim == 0 || r < 12)
         return VERTEX_W'($urandom_range(0, NUM_V - 1));
      if (hot >= 0 && hot < lim && r < 50)
         return VERTEX_W'(hot);
      return VERTEX_W'($urandom_range(0, lim - 1));
   endfunction

   task automatic send_request(logic [REQ_W-1:0] kind, logic [VERTEX_W-1:0] src,
                               logic [VERTEX_W-1:0] dst);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_from_vertex <= src;
      req_to_vertex   <= dst;
      do @(posedge clock); while (busy);
      apply_graph_request(kind, src, dst);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic reg_sel, logic [CSR_DW-1:0] value);
      settle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_VCOUNT)
         vcount_shadow = value[VCOUNT_W-1:0];
      else
         undir_shadow = value[0];
   endtask

   task automatic configure(int vcount, logic undir);
      write_csr(REG_VCOUNT, ($urandom() & ~32'h1F) | vcount);
      write_csr(REG_UNDIR, ($urandom() & ~32'h1) | {31'b0, undir});
   endtask

   task automatic test_directed();
      send_request(REQ_LIST, 0, 0);
      send_request(REQ_ADD, 0, 15);
      send_request(REQ_ADD, 0, 0);
      send_request(REQ_ADD, 0, 15);
      send_request(REQ_QUERY, 0, 15);
      send_request(REQ_QUERY, 15, 0);
      send_request(REQ_LIST, 0, 7);
      send_request(REQ_ADD, 15, 3);
      send_request(REQ_LIST, 15, 0);
      send_request(REQ_NONE, 15, 15);
      send_request(REQ_QUERY, 15, 3);
      // shrunk vertex count: out of range and hidden edges
      configure(4, 1'b0);
      send_request(REQ_ADD, 5, 1);
      send_request(REQ_ADD, 1, 4);
      send_request(REQ_QUERY, 1, 9);
      send_request(REQ_LIST, 7, 0);
      send_request(REQ_LIST, 0, 0);
      // zero vertex count rejects everything
      configure(0, 1'b0);
      send_request(REQ_ADD, 0, 0);
      send_request(REQ_LIST, 0, 0);
      send_request(REQ_NONE, 0, 0);
      // count above the maximum saturates
      configure(31, 1'b0);
      send_request(REQ_LIST, 0, 0);
      configure(16, 1'b1);
      send_request(REQ_ADD, 3, 3);
      send_request(REQ_LIST, 3, 0);
      send_request(REQ_ADD, 2, 9);
      send_request(REQ_QUERY, 9, 2);
      send_request(REQ_LIST, 9, 0);
   endtask

   task automatic test_full_row();
      logic [VERTEX_W-1:0] order [NUM_V];
      logic [VERTEX_W-1:0] tmp;
      logic [VERTEX_W-1:0] row;
      int j;
      configure(16, 1'b0);
      for (int i = 0; i < NUM_V; i++)
         order[i] = VERTEX_W'(i);
      for (int i = NUM_V - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      row = VERTEX_W'($urandom_range(0, NUM_V - 1));
      for (int i = 0; i < NUM_V; i++)
         send_request(REQ_ADD, row, order[i]);
      send_request(REQ_LIST, row, 0);
      send_request(REQ_QUERY, row, order[0]);
   endtask

   task automatic test_random_phases();
      int vcounts [6] = '{16, 1, 2, 9, 17, 0};
      logic undirs [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      int hot;
      int r;
      logic [REQ_W-1:0] kind;
      vcounts[5] = $urandom_range(0, 31);
      undirs[5] = 1'($urandom_range(0, 1));
      for (int p = 0; p < 6; p++) begin
         configure(vcounts[p], undirs[p]);
         no_gaps = (p == 2);
         hot = $urandom_range(0, NUM_V - 1);
         if (vertex_limit() > 0)
            hot = hot % vertex_limit();
         for (int n = 0; n < 36; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               kind = REQ_ADD;
            else if (r < 70)
               kind = REQ_QUERY;
            else if (r < 95)
               kind = REQ_LIST;
            else
               kind = REQ_NONE;
            send_request(kind, pick_vertex(hot), pick_vertex(-1));
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = '0;
      req_from_vertex = '0;
      req_to_vertex   = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      mismatches      = 0;
      no_gaps         = 1'b0;
      vcount_shadow   = VCOUNT_RESET;
      undir_shadow    = UNDIR_RESET;
      for (int i = 0; i < NUM_V; i++)
         graph_rows[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_row();
      test_random_phases();
      settle();
      if (mismatches == 0)
         $display("tb_adjacency_matrix_store: done, clean");
      else
         $display("tb_adjacency_matrix_store: done, errors");
      $finish;
   end

endmodule
